FILE: design/tsvf_pkg.sv
// Shared types and constants for the trapezoidal state variable filter.
// No dependencies; imported by every module of the block.
`default_nettype none

package tsvf_pkg;

  // Parameter defaults
  localparam int SAMPLE_BITS_DEF    = 24;
  localparam int COEF_FRAC_BITS_DEF = 16;
  localparam int CHANNELS_DEF       = 2;

  // Fixed datapath widths: integrators are 32 bit, coefficients stay below 4.0
  localparam int INTEG_W = 32;
  localparam int V_W     = 37;  // multiplier data operand (ic1, v3, v1)
  localparam int ACC_W   = 40;  // v1, v2, band, output tap before saturation

  // Configuration register indexes
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_FILTER_TYPE = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_DAMPING_K   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_A1_LEFT     = 3'd2;
  localparam int                   REG_CH_STRIDE   = 3;   // a1, a2, a3 per channel

  // Output tap codes; the unused code selects high-pass
  localparam int FT_W = 2;
  localparam logic [FT_W-1:0] FT_LOWPASS  = 2'd0;
  localparam logic [FT_W-1:0] FT_BANDPASS = 2'd1;
  localparam logic [FT_W-1:0] FT_HIGHPASS = 2'd2;

  // Datapath step codes
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_IDLE = 3'd0;
  localparam logic [STEP_W-1:0] STEP_LOAD = 3'd1;
  localparam logic [STEP_W-1:0] STEP_M0   = 3'd2;
  localparam logic [STEP_W-1:0] STEP_M1   = 3'd3;
  localparam logic [STEP_W-1:0] STEP_M2   = 3'd4;
  localparam logic [STEP_W-1:0] STEP_M3   = 3'd5;
  localparam logic [STEP_W-1:0] STEP_M4   = 3'd6;
  localparam logic [STEP_W-1:0] STEP_UPD  = 3'd7;

  // Controller to datapath command
  typedef struct packed {
    logic              capture;   // take sample and channel from the input port
    logic [STEP_W-1:0] step;      // datapath operation this cycle
    logic              out_load;  // load the output register
  } cmd_t;

endpackage

`default_nettype wire

FILE: design/tsvf_cfg.sv
// Configuration register file of the state variable filter.
// Depends on tsvf_pkg.
`default_nettype none

module tsvf_cfg #(
  parameter int COEF_FRAC_BITS = tsvf_pkg::COEF_FRAC_BITS_DEF,
  parameter int CHANNELS       = tsvf_pkg::CHANNELS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [tsvf_pkg::REG_IDX_W-1:0]       cfg_index,
  input  wire logic [COEF_FRAC_BITS+1:0]            cfg_data,
  output logic [tsvf_pkg::FT_W-1:0]                 filter_type,
  output logic [COEF_FRAC_BITS+1:0]                 damping_k,
  output logic [COEF_FRAC_BITS+1:0]                 coef_a1 [CHANNELS],
  output logic [COEF_FRAC_BITS+1:0]                 coef_a2 [CHANNELS],
  output logic [COEF_FRAC_BITS+1:0]                 coef_a3 [CHANNELS]
);
  import tsvf_pkg::*;

  localparam int COEF_BITS = COEF_FRAC_BITS + 2;
  localparam logic [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) << COEF_FRAC_BITS;

  logic [FT_W-1:0]      filter_type_r;
  logic [COEF_BITS-1:0] damping_k_r;
  logic [COEF_BITS-1:0] coef_a1_r [CHANNELS];
  logic [COEF_BITS-1:0] coef_a2_r [CHANNELS];
  logic [COEF_BITS-1:0] coef_a3_r [CHANNELS];
  logic                 wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_type_r <= FT_LOWPASS;
      damping_k_r   <= COEF_ONE;
      for (int c = 0; c < CHANNELS; c++) begin
        coef_a1_r[c] <= COEF_ONE;
        coef_a2_r[c] <= '0;
        coef_a3_r[c] <= '0;
      end
    end else if (wr) begin
      if (cfg_index == REG_FILTER_TYPE) filter_type_r <= cfg_data[FT_W-1:0];
      if (cfg_index == REG_DAMPING_K)   damping_k_r   <= cfg_data;
      for (int c = 0; c < CHANNELS; c++) begin
        if (cfg_index == REG_IDX_W'(REG_A1_LEFT + REG_CH_STRIDE * c))
          coef_a1_r[c] <= cfg_data;
        if (cfg_index == REG_IDX_W'(REG_A1_LEFT + REG_CH_STRIDE * c + 1))
          coef_a2_r[c] <= cfg_data;
        if (cfg_index == REG_IDX_W'(REG_A1_LEFT + REG_CH_STRIDE * c + 2))
          coef_a3_r[c] <= cfg_data;
      end
    end
  end

  assign filter_type = filter_type_r;
  assign damping_k   = damping_k_r;
  assign coef_a1     = coef_a1_r;
  assign coef_a2     = coef_a2_r;
  assign coef_a3     = coef_a3_r;

endmodule

`default_nettype wire

FILE: design/tsvf_ctrl.sv
// Sequencing controller of the state variable filter: steps one item through
// load, five shared-multiplier passes, state update and output. Uses tsvf_pkg.
`default_nettype none

module tsvf_ctrl (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output tsvf_pkg::cmd_t  cmd
);
  import tsvf_pkg::*;

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] S_IDLE = 4'd0;
  localparam logic [ST_W-1:0] S_LOAD = 4'd1;
  localparam logic [ST_W-1:0] S_M0   = 4'd2;
  localparam logic [ST_W-1:0] S_M1   = 4'd3;
  localparam logic [ST_W-1:0] S_M2   = 4'd4;
  localparam logic [ST_W-1:0] S_M3   = 4'd5;
  localparam logic [ST_W-1:0] S_M4   = 4'd6;
  localparam logic [ST_W-1:0] S_UPD  = 4'd7;
  localparam logic [ST_W-1:0] S_FIN  = 4'd8;

  logic [ST_W-1:0] state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;
  logic            accept;

  assign out_free  = ~out_valid_r | out_tready;
  assign in_tready = (state_r == S_IDLE) | ((state_r == S_FIN) & out_free);
  assign accept    = in_tvalid & in_tready;

  always_comb begin
    state_nxt     = state_r;
    cmd.capture   = accept;
    cmd.step      = STEP_IDLE;
    cmd.out_load  = 1'b0;
    out_valid_nxt = out_valid_r & ~out_tready;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = S_LOAD;
      S_LOAD: begin cmd.step = STEP_LOAD; state_nxt = S_M0;  end
      S_M0:   begin cmd.step = STEP_M0;   state_nxt = S_M1;  end
      S_M1:   begin cmd.step = STEP_M1;   state_nxt = S_M2;  end
      S_M2:   begin cmd.step = STEP_M2;   state_nxt = S_M3;  end
      S_M3:   begin cmd.step = STEP_M3;   state_nxt = S_M4;  end
      S_M4:   begin cmd.step = STEP_M4;   state_nxt = S_UPD; end
      S_UPD:  begin cmd.step = STEP_UPD;  state_nxt = S_FIN; end
      S_FIN: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = accept ? S_LOAD : S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

FILE: design/tsvf_dp.sv
// Datapath of the state variable filter: integrator state, one shared
// coefficient multiplier with rounding, accumulators and output register.
// Depends on tsvf_pkg; driven by commands from tsvf_ctrl.
`default_nettype none

module tsvf_dp #(
  parameter int SAMPLE_BITS    = tsvf_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = tsvf_pkg::COEF_FRAC_BITS_DEF,
  parameter int CHANNELS       = tsvf_pkg::CHANNELS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire tsvf_pkg::cmd_t                 cmd,
  input  wire logic [SAMPLE_BITS-1:0]         sample_in,
  input  wire logic                           channel,
  input  wire logic [tsvf_pkg::FT_W-1:0]      filter_type,
  input  wire logic [COEF_FRAC_BITS+1:0]      damping_k,
  input  wire logic [COEF_FRAC_BITS+1:0]      coef_a1 [CHANNELS],
  input  wire logic [COEF_FRAC_BITS+1:0]      coef_a2 [CHANNELS],
  input  wire logic [COEF_FRAC_BITS+1:0]      coef_a3 [CHANNELS],
  output logic [SAMPLE_BITS-1:0]              sample_out,
  output logic                                out_channel,
  output logic                                clipped
);
  import tsvf_pkg::*;

  localparam int COEF_BITS = COEF_FRAC_BITS + 2;
  localparam int P_W       = COEF_BITS + 1 + V_W;
  localparam logic signed [P_W:0] RND_HALF = (P_W + 1)'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] I_MAX = ACC_W'({1'b0, {(INTEG_W - 1){1'b1}}});
  localparam logic signed [ACC_W-1:0] I_MIN = -I_MAX - 1;
  localparam logic signed [ACC_W-1:0] S_MAX = ACC_W'({1'b0, {(SAMPLE_BITS - 1){1'b1}}});
  localparam logic signed [ACC_W-1:0] S_MIN = -S_MAX - 1;

  // item registers
  logic signed [SAMPLE_BITS-1:0] x_r;
  logic                          chan_bit_r;
  logic signed [INTEG_W-1:0]     ic1_r, ic2_r;
  logic signed [V_W-1:0]         v3_r;
  logic signed [P_W-1:0]         prod_r;
  logic signed [ACC_W-1:0]       v1_r, v2_r, band_r;
  logic                          clip_r;
  // per-channel state
  logic signed [INTEG_W-1:0]     integ1_r [CHANNELS];
  logic signed [INTEG_W-1:0]     integ2_r [CHANNELS];
  // output register
  logic [SAMPLE_BITS-1:0]        sample_out_r;
  logic                          out_chan_r, out_clip_r;

  logic                          ch;
  logic [COEF_BITS-1:0]          mul_c;
  logic signed [V_W-1:0]         mul_v;
  logic signed [P_W-1:0]         prod_nxt;
  logic signed [P_W:0]           psum, pshift;
  logic signed [ACC_W-1:0]       rnd;
  logic signed [ACC_W-1:0]       t1, t2, s1, s2;
  logic                          hit1, hit2;
  logic signed [ACC_W-1:0]       x_ext, y_raw, y_sat;
  logic                          y_hit;

  // a single-channel build maps the right channel onto the left state
  assign ch = (CHANNELS > 1) ? chan_bit_r : 1'b0;

  // multiplier operand select
  always_comb begin
    mul_c = '0;
    mul_v = '0;
    unique case (cmd.step)
      STEP_M0: begin mul_c = coef_a1[ch]; mul_v = V_W'(ic1_r); end
      STEP_M1: begin mul_c = coef_a2[ch]; mul_v = v3_r;        end
      STEP_M2: begin mul_c = coef_a2[ch]; mul_v = V_W'(ic1_r); end
      STEP_M3: begin mul_c = coef_a3[ch]; mul_v = v3_r;        end
      STEP_M4: begin mul_c = damping_k;   mul_v = v1_r[V_W-1:0]; end
      default: ;
    endcase
  end

  assign prod_nxt = $signed({1'b0, mul_c}) * mul_v;

  // round half up to the sample scale
  assign psum   = $signed({prod_r[P_W-1], prod_r}) + RND_HALF;
  assign pshift = psum >>> COEF_FRAC_BITS;
  assign rnd    = pshift[ACC_W-1:0];

  // integrator updates
  always_comb begin
    t1   = (v1_r <<< 1) - ACC_W'(ic1_r);
    t2   = (v2_r <<< 1) - ACC_W'(ic2_r);
    hit1 = (t1 > I_MAX) | (t1 < I_MIN);
    hit2 = (t2 > I_MAX) | (t2 < I_MIN);
    s1   = (t1 > I_MAX) ? I_MAX : ((t1 < I_MIN) ? I_MIN : t1);
    s2   = (t2 > I_MAX) ? I_MAX : ((t2 < I_MIN) ? I_MIN : t2);
  end

  // output tap
  always_comb begin
    x_ext = ACC_W'(x_r);
    unique case (filter_type)
      FT_LOWPASS:  y_raw = v2_r;
      FT_BANDPASS: y_raw = band_r;
      default:     y_raw = x_ext - band_r - v2_r;
    endcase
    y_hit = (y_raw > S_MAX) | (y_raw < S_MIN);
    y_sat = (y_raw > S_MAX) ? S_MAX : ((y_raw < S_MIN) ? S_MIN : y_raw);
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (cmd.capture) begin
      x_r        <= $signed(sample_in);
      chan_bit_r <= channel;
    end
    unique case (cmd.step)
      STEP_LOAD: begin
        ic1_r  <= integ1_r[ch];
        ic2_r  <= integ2_r[ch];
        v3_r   <= V_W'(x_r) - V_W'(integ2_r[ch]);
        clip_r <= 1'b0;
      end
      STEP_M1:  v1_r   <= rnd;
      STEP_M2:  v1_r   <= v1_r + rnd;
      STEP_M3:  v2_r   <= ACC_W'(ic2_r) + rnd;
      STEP_M4:  v2_r   <= v2_r + rnd;
      STEP_UPD: begin
        band_r <= rnd;
        clip_r <= hit1 | hit2;
      end
      default: ;
    endcase
    if (cmd.out_load) begin
      sample_out_r <= y_sat[SAMPLE_BITS-1:0];
      out_chan_r   <= chan_bit_r;
      out_clip_r   <= clip_r | y_hit;
    end
  end

  // integrator state, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        integ1_r[c] <= '0;
        integ2_r[c] <= '0;
      end
    end else if (cmd.step == STEP_UPD) begin
      integ1_r[ch] <= s1[INTEG_W-1:0];
      integ2_r[ch] <= s2[INTEG_W-1:0];
    end
  end

  assign sample_out  = sample_out_r;
  assign out_channel = out_chan_r;
  assign clipped     = out_clip_r;

endmodule

`default_nettype wire

FILE: design/tpt_state_variable_filter.sv
// Two-channel trapezoidal state variable filter, top level.
// Channels:
//   in_*   stream input; tdata = sample_in (signed), tuser = channel.
//   out_*  stream output; tdata = sample_out (signed), tuser = {clipped, out_channel}.
//   cfg_*  register writes: index 0 filter type, 1 damping k, 2..4 left a1..a3,
//          5..7 right a1..a3; coefficients unsigned Q2.COEF_FRAC_BITS.
// Timing: an item is taken, then runs load, five passes through one shared
//   coefficient multiplier, an integrator update and an output step. The next
//   item is taken in the cycle the previous result is written, so the block takes
//   no new item before the last one is through, since the five products share
//   that multiplier.
// The output register decouples the two sides: a new item is taken and
//   processed while the previous result still waits. If the receiver stalls,
//   the finished item holds in the last step until the output register frees.
// Reset (rst_n low, synchronous): integrators of both channels go to zero,
//   registers to their defaults (low-pass, k = a1 = 1.0, a2 = a3 = 0), and the
//   output channel empties. No clearing pass is needed.
// Depends on tsvf_pkg, tsvf_cfg, tsvf_ctrl, tsvf_dp.
`default_nettype none

module tpt_state_variable_filter #(
  parameter int SAMPLE_BITS    = tsvf_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = tsvf_pkg::COEF_FRAC_BITS_DEF,
  parameter int CHANNELS       = tsvf_pkg::CHANNELS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // input item
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  input  wire logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] in_tdata,  // [0+] sample_in
  input  wire logic                                 in_tuser,   // [0] channel
  // result item
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0]  out_tdata,  // [0+] sample_out
  output logic [1:0]                                out_tuser,  // [0] out_channel, [1] clipped
  // configuration writes
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [tsvf_pkg::REG_IDX_W-1:0]       cfg_index,
  input  wire logic [COEF_FRAC_BITS+1:0]            cfg_data
);
  import tsvf_pkg::*;

  localparam int TDATA_W   = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int COEF_BITS = COEF_FRAC_BITS + 2;

  cmd_t                   cmd;
  logic [FT_W-1:0]        filter_type;
  logic [COEF_BITS-1:0]   damping_k;
  logic [COEF_BITS-1:0]   coef_a1 [CHANNELS];
  logic [COEF_BITS-1:0]   coef_a2 [CHANNELS];
  logic [COEF_BITS-1:0]   coef_a3 [CHANNELS];
  logic [SAMPLE_BITS-1:0] sample_out;
  logic                   out_channel;
  logic                   clipped;

  tsvf_cfg #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .CHANNELS       (CHANNELS)
  ) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .filter_type (filter_type),
    .damping_k   (damping_k),
    .coef_a1     (coef_a1),
    .coef_a2     (coef_a2),
    .coef_a3     (coef_a3)
  );

  tsvf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  tsvf_dp #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .CHANNELS       (CHANNELS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sample_in   (in_tdata[SAMPLE_BITS-1:0]),
    .channel     (in_tuser),
    .filter_type (filter_type),
    .damping_k   (damping_k),
    .coef_a1     (coef_a1),
    .coef_a2     (coef_a2),
    .coef_a3     (coef_a3),
    .sample_out  (sample_out),
    .out_channel (out_channel),
    .clipped     (clipped)
  );

  // pad the sample up to whole bytes with zeros
  assign out_tdata = TDATA_W'(sample_out);
  assign out_tuser = {clipped, out_channel};

`ifndef SYNTHESIS
  // a freshly written result is presented next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_tvalid)
    else $error("output register loaded but result not presented");

  // never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_tvalid || out_tready))
    else $error("pending result overwritten");

  // one item at a time: after acceptance the input side closes
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while an item is in progress");

  // datapath captures exactly on acceptance
  a_capture: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture == (in_tvalid && in_tready))
    else $error("sample capture out of step with input handshake");
`endif

endmodule

`default_nettype wire

FILE: sim/tb_tpt_state_variable_filter.sv
// Testbench for tpt_state_variable_filter: random and directed audio items on both
// channels, checked against a fixed-point filter model kept here. Needs tsvf_pkg.
`timescale 1ns / 1ps

module tb_tpt_state_variable_filter;
  import tsvf_pkg::*;

  // register map beyond what the package names
  localparam logic [REG_IDX_W-1:0] REG_A2_LEFT  = REG_A1_LEFT + 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_A3_LEFT  = REG_A1_LEFT + 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_A1_RIGHT = REG_A1_LEFT + 3'(REG_CH_STRIDE);
  localparam logic [REG_IDX_W-1:0] REG_A2_RIGHT = REG_A1_RIGHT + 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_A3_RIGHT = REG_A1_RIGHT + 3'd2;
  localparam int NUM_REGS = 8;

  // the fourth tap code has no name in the package; the block treats it as high-pass
  localparam logic [FT_W-1:0] FT_SPARE = 2'd3;

  localparam logic [17:0] COEF_MAX = 18'h3FFFF;
  localparam logic [17:0] COEF_ONE = 18'd65536;
  localparam logic [23:0] FULL_POS = 24'h7FFFFF;
  localparam logic [23:0] FULL_NEG = 24'h800000;
  localparam longint INTEG_HI = 64'sd2147483647;
  localparam longint INTEG_LO = -64'sd2147483648;
  localparam longint AUDIO_HI = 64'sd8388607;
  localparam longint AUDIO_LO = -64'sd8388608;

  localparam int HOLD_CYCLES  = 400;   // long receiver stall, fills the block
  localparam int QUIET_LIMIT  = 4000;  // cycles without any handshake
  localparam int PHASE_ITEMS  = 175;   // eight random phases, about 1400 items

  typedef struct {
    logic signed [23:0] x;
    logic               ch;
  } audio_item_t;

  typedef struct {
    logic [23:0] y;
    logic        chan;
    logic        clip;
  } filter_result_t;

  logic clk;
  logic rst_n = 1'b0;

  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;   // [23:0] sample_in
  logic        in_tuser   = 1'b0; // [0] channel
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;         // [23:0] sample_out
  logic [1:0]  out_tuser;         // [0] out_channel, [1] clipped
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [17:0] cfg_data  = '0;

  tpt_state_variable_filter uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Filter model: shadow registers and both channels' integrators.
  // All arithmetic is done in 64 bits, where every intermediate fits exactly.
  // ---------------------------------------------------------------------------
  logic [FT_W-1:0] tap_sel;
  logic [17:0]     damp_k;
  logic [17:0]     a1_coef [2];
  logic [17:0]     a2_coef [2];
  logic [17:0]     a3_coef [2];
  logic signed [31:0] integ_one [2];
  logic signed [31:0] integ_two [2];

  filter_result_t expected_outputs [$];
  audio_item_t    sample_queue [$];

  int  mismatch_count = 0;
  int  quiet_cycles   = 0;
  int  send_idle_pct  = 0;
  int  stall_pct      = 0;
  bit  hold_armed     = 1'b0;
  int  hold_count     = 0;
  bit  in_took        = 1'b0;   // item taken at the last rising edge
  logic [17:0] reg_plan [NUM_REGS];

  // coefficient product rounded back to sample scale, half rounds up
  function automatic longint scale_coef(logic [17:0] c, longint v);
    longint cv;
    cv = c;
    return (cv * v + 64'sd32768) >>> 16;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi, inout bit hit);
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (v < lo) begin
      hit = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // one trapezoidal step of the addressed channel; updates its integrators
  function automatic filter_result_t filter_step(logic signed [23:0] xin, logic ch);
    filter_result_t r;
    longint x, ic1, ic2, v1, v2, v3, band, y;
    bit hit;
    hit = 1'b0;
    x   = xin;
    ic1 = integ_one[ch];
    ic2 = integ_two[ch];
    v3  = x - ic2;
    v1  = scale_coef(a1_coef[ch], ic1) + scale_coef(a2_coef[ch], v3);
    v2  = ic2 + scale_coef(a2_coef[ch], ic1) + scale_coef(a3_coef[ch], v3);
    integ_one[ch] = 32'(clamp(2 * v1 - ic1, INTEG_LO, INTEG_HI, hit));
    integ_two[ch] = 32'(clamp(2 * v2 - ic2, INTEG_LO, INTEG_HI, hit));
    band = scale_coef(damp_k, v1);
    case (tap_sel)
      FT_LOWPASS:  y = v2;
      FT_BANDPASS: y = band;
      default:     y = x - band - v2;   // high-pass, spare code too
    endcase
    y = clamp(y, AUDIO_LO, AUDIO_HI, hit);
    r.y    = 24'(y);
    r.chan = ch;
    r.clip = hit;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH at %0t: %s got %0h want %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: everything sampled at the rising edge. Register writes and input
  // items go into the model; result items are checked against the oldest
  // expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    filter_result_t want;
    if (!rst_n) begin
      in_took      <= 1'b0;
      quiet_cycles <= 0;
      tap_sel = FT_LOWPASS;
      damp_k  = COEF_ONE;
      for (int c = 0; c < 2; c++) begin
        a1_coef[c]   = COEF_ONE;
        a2_coef[c]   = '0;
        a3_coef[c]   = '0;
        integ_one[c] = '0;
        integ_two[c] = '0;
      end
    end else begin
      in_took <= in_tvalid && in_tready;
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FILTER_TYPE: tap_sel    = cfg_data[FT_W-1:0];  // upper data bits dropped
          REG_DAMPING_K:   damp_k     = cfg_data;
          REG_A1_LEFT:     a1_coef[0] = cfg_data;
          REG_A2_LEFT:     a2_coef[0] = cfg_data;
          REG_A3_LEFT:     a3_coef[0] = cfg_data;
          REG_A1_RIGHT:    a1_coef[1] = cfg_data;
          REG_A2_RIGHT:    a2_coef[1] = cfg_data;
          REG_A3_RIGHT:    a3_coef[1] = cfg_data;
          default: ;
        endcase
      end

      if (in_tvalid && in_tready)
        expected_outputs.push_back(filter_step($signed(in_tdata), in_tuser));

      if (out_tvalid && out_tready) begin
        if (expected_outputs.size() == 0) begin
          report_mismatch("result item with nothing expected", out_tdata, 0);
        end else begin
          want = expected_outputs.pop_front();
          if (out_tdata !== want.y)
            report_mismatch("sample_out", out_tdata, want.y);
          if (out_tuser[0] !== want.chan)
            report_mismatch("out_channel", out_tuser[0], want.chan);
          if (out_tuser[1] !== want.clip)
            report_mismatch("clipped", out_tuser[1], want.clip);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender: at the falling edge, once the offered item is gone (or none is
  // offered), offer the next pending item or go idle.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    audio_item_t nxt;
    if (rst_n && (!in_tvalid || in_took)) begin
      if (sample_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = sample_queue.pop_front();
        in_tdata  <= nxt.x;
        in_tuser  <= nxt.ch;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls; once armed, one long hold-off counted here
  always @(negedge clk) begin
    if (hold_armed && hold_count < HOLD_CYCLES) begin
      hold_count <= hold_count + 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Watchdog: no handshake on any channel for too long
  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_item(logic [23:0] x, logic ch);
    audio_item_t it;
    it.x  = x;
    it.ch = ch;
    sample_queue.push_back(it);
  endtask

  function automatic logic [17:0] to_q216(real r);
    if (r * 65536.0 >= 262143.0)
      return COEF_MAX;
    return 18'($rtoi(r * 65536.0 + 0.5));
  endfunction

  // usual SVF coefficients from prewarped gain g per channel and damping k
  task automatic plan_design(real g_l, real g_r, real k);
    real a1l, a1r;
    a1l = 1.0 / (1.0 + g_l * (g_l + k));
    a1r = 1.0 / (1.0 + g_r * (g_r + k));
    reg_plan[REG_DAMPING_K] = to_q216(k);
    reg_plan[REG_A1_LEFT]   = to_q216(a1l);
    reg_plan[REG_A2_LEFT]   = to_q216(g_l * a1l);
    reg_plan[REG_A3_LEFT]   = to_q216(g_l * g_l * a1l);
    reg_plan[REG_A1_RIGHT]  = to_q216(a1r);
    reg_plan[REG_A2_RIGHT]  = to_q216(g_r * a1r);
    reg_plan[REG_A3_RIGHT]  = to_q216(g_r * g_r * a1r);
  endtask

  // write the whole register plan, back to back
  task automatic program_regs();
    for (int i = 0; i < NUM_REGS; i++) begin
      @(negedge clk);
      cfg_index <= 3'(i);
      cfg_data  <= reg_plan[i];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // block idle: nothing pending, nothing offered, nothing outstanding
  task automatic wait_idle();
    while (sample_queue.size() != 0 || in_tvalid || expected_outputs.size() != 0)
      @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Mostly held levels on both channels (step responses, so the integrators
  // actually settle), some full-range noise and rail values in between.
  task automatic queue_random(int count);
    int left, run;
    logic [23:0] level;
    logic ch;
    left = count;
    while (left > 0) begin
      case ($urandom_range(0, 9))
        0:       level = FULL_POS;
        1:       level = FULL_NEG;
        2, 3:    level = 24'($urandom_range(0, 4095) - 2048);
        default: level = 24'($urandom);
      endcase
      if ($urandom_range(0, 3) == 0) begin
        push_item(level, 1'($urandom_range(0, 1)));
        left--;
      end else begin
        run = $urandom_range(2, 24);
        ch  = 1'($urandom_range(0, 1));
        for (int i = 0; i < run && left > 0; i++) begin
          push_item(level, ch);
          ch = ~ch;
          left--;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: low-pass with a moderate design, rails and values near zero
    plan_design(0.3, 1.2, 0.7);
    reg_plan[REG_FILTER_TYPE] = FT_LOWPASS;
    program_regs();
    push_item(FULL_POS, 1'b0);
    push_item(FULL_POS, 1'b1);
    push_item(FULL_NEG, 1'b0);
    push_item(FULL_NEG, 1'b1);
    push_item(24'd0, 1'b0);
    push_item(24'hFFFFFF, 1'b1);
    push_item(24'd1, 1'b0);
    wait_idle();

    // band-pass with zero damping: tap is forced to zero
    reg_plan[REG_FILTER_TYPE] = FT_BANDPASS;
    reg_plan[REG_DAMPING_K]   = '0;
    program_regs();
    push_item(FULL_POS, 1'b0);
    push_item(FULL_NEG, 1'b1);
    push_item(24'd12345, 1'b0);
    wait_idle();

    // spare tap code (all data bits set) and every coefficient at maximum:
    // the loop is unstable and both integrators run into saturation
    foreach (reg_plan[i]) reg_plan[i] = COEF_MAX;
    program_regs();
    for (int i = 0; i < 6; i++)
      push_item(i[0] ? FULL_NEG : FULL_POS, 1'(i >> 1));
    wait_idle();

    // high-pass with upper data bits set on the tap register, all a's zero
    foreach (reg_plan[i]) reg_plan[i] = '0;
    reg_plan[REG_FILTER_TYPE] = {16'hFFFF, FT_HIGHPASS};
    reg_plan[REG_DAMPING_K]   = COEF_MAX;
    program_regs();
    push_item(FULL_POS, 1'b0);
    push_item(FULL_NEG, 1'b1);
    push_item(24'd0, 1'b1);
    push_item(24'd0, 1'b0);
    wait_idle();

    // band-pass with damping k = 3.9, sane design again
    plan_design(0.05, 2.5, 3.9);
    reg_plan[REG_FILTER_TYPE] = FT_BANDPASS;
    program_regs();
    push_item(FULL_POS, 1'b1);
    push_item(FULL_POS, 1'b0);
    push_item(24'h400000, 1'b1);
    wait_idle();

    // random phases, idling pattern cycles: none, sender, receiver, both
    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 53; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 53; end
        default: begin send_idle_pct = 37; stall_pct = 37; end
      endcase
      if (p == 4) begin
        // noise: raw register values, mostly unstable filters
        foreach (reg_plan[i]) reg_plan[i] = 18'($urandom_range(0, 262143));
      end else begin
        plan_design(0.02 + $urandom_range(0, 2000) / 1000.0,
                    0.02 + $urandom_range(0, 2000) / 1000.0,
                    0.1 + $urandom_range(0, 1900) / 1000.0);
        case (p % 4)
          0: reg_plan[REG_FILTER_TYPE] = FT_LOWPASS;
          1: reg_plan[REG_FILTER_TYPE] = FT_BANDPASS;
          2: reg_plan[REG_FILTER_TYPE] = FT_HIGHPASS;
          default: reg_plan[REG_FILTER_TYPE] = FT_SPARE;
        endcase
      end
      program_regs();
      // sender runs flat out here, so the long hold-off backs the block up
      if (p == 4)
        hold_armed = 1'b1;
      queue_random(PHASE_ITEMS);
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (expected_outputs.size() != 0)
      report_mismatch("results never delivered", expected_outputs.size(), 0);
    if (mismatch_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: sim.f
design/tsvf_pkg.sv
design/tsvf_cfg.sv
design/tsvf_ctrl.sv
design/tsvf_dp.sv
design/tpt_state_variable_filter.sv
sim/tb_tpt_state_variable_filter.sv
